// ===== hw/rtl/ansi_truecolor_cell_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the true-colour cell parser
// Clocked, reset-qualified property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ANSI_TRUECOLOR_CELL_PARSER_MACROS_SVH
`define ANSI_TRUECOLOR_CELL_PARSER_MACROS_SVH

// Assert an implication on the rising clock, disabled during reset
`define ATC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication checked in the following cycle
`define ATC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/atcp_pkg.sv =====
// ----------------------------------------------------------------------------
// atcp_pkg
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package atcp_pkg;

    localparam logic [7:0] ESC_CODE   = 8'h1B;
    localparam logic [7:0] CR_CODE    = 8'h0D;
    localparam logic [7:0] LF_CODE    = 8'h0A;
    localparam logic [7:0] LBRK_CODE  = 8'h5B;
    localparam logic [7:0] SEMI_CODE  = 8'h3B;
    localparam logic [7:0] M_CODE     = 8'h6D;
    localparam logic [7:0] ZERO_CODE  = 8'h30;
    localparam logic [7:0] NINE_CODE  = 8'h39;
    localparam int unsigned FG_CODE   = 38;
    localparam int unsigned BG_CODE   = 48;
    localparam int unsigned TC_CODE   = 2;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_SGR
    } mode_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EMIT
    } bk_state_t;

    // Work handed from front end to back end
    typedef struct packed {
        logic        is_run;    // apply stored SGR run, no cell
        logic        cell_a;    // first cell present
        logic [31:0] bytes_a;
        logic [2:0]  len_a;
        logic        cell_b;    // second cell present
        logic [7:0]  byte_b;
        logic [7:0]  rows_a;
        logic        flush;     // stream end: reset colours after cells
    } job_t;

    typedef struct packed {
        logic        on;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } colour_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = 3'd1;
            if ((b & 8'h80) == 8'h00)      len = 3'd1;
            else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
            else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
            else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
            return len;
        end
    endfunction

endpackage

// ===== hw/rtl/atcp_front.sv =====
// ----------------------------------------------------------------------------
// atcp_front
// Accepts stream words, assembles glyphs, parses SGR numbers into the
// parameter store and posts jobs to the queue.
// ----------------------------------------------------------------------------
module atcp_front #(
    parameter int MAX_PARAMS = 16,
    parameter int NUM_BITS   = 16,
    parameter int CW         = $clog2(MAX_PARAMS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            text_byte,
    input  logic                  stream_end,
    output logic                  job_valid,
    input  logic                  job_ready,
    output atcp_pkg::job_t        job,
    input  logic                  run_busy,
    output logic [CW-1:0]         run_count,
    output logic                  pw_en,
    output logic [CW-1:0]         pw_addr,
    output logic [NUM_BITS-1:0]   pw_data
);
    import atcp_pkg::*;

    localparam logic [NUM_BITS-1:0] NUM_MAX = {NUM_BITS{1'b1}};

    mode_t               mode_reg, mode_next;
    logic [31:0]         gbuf_reg, gbuf_next;
    logic [2:0]          gneed_reg, gneed_next;
    logic [2:0]          ghave_reg, ghave_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] acc_reg, acc_next;
    logic [7:0]          rows_reg, rows_next;
    logic                accept;
    logic [NUM_BITS+3:0] acc_x10;

    // Stall while the queue is full or a run is being applied
    assign in_ready  = job_ready && !run_busy;
    assign accept    = in_valid && in_ready;
    assign run_count = cnt_reg;
    assign acc_x10   = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                     + {{NUM_BITS{1'b0}}, 4'(text_byte - ZERO_CODE)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            gbuf_reg  <= '0;
            gneed_reg <= '0;
            ghave_reg <= '0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            rows_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            gbuf_reg  <= gbuf_next;
            gneed_reg <= gneed_next;
            ghave_reg <= ghave_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            rows_reg  <= rows_next;
        end
    end

    // Classify the word and build the job
    always_comb
    begin
        logic       txt;
        logic [7:0] tb;
        logic [2:0] len;
        logic       push;
        mode_next  = mode_reg;
        gbuf_next  = gbuf_reg;
        gneed_next = gneed_reg;
        ghave_next = ghave_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rows_next  = rows_reg;
        job        = '0;
        job.rows_a = rows_reg;
        job.flush  = stream_end;
        txt        = 1'b0;
        tb         = text_byte;
        push       = 1'b0;
        len        = 3'd1;
        if (gneed_reg != 3'd0)
        begin
            gbuf_next = gbuf_reg | ({24'd0, text_byte} << {ghave_reg[1:0], 3'b000});
            ghave_next = ghave_reg + 3'd1;
            if (ghave_next >= gneed_reg || stream_end)
            begin
                job.cell_a = 1'b1;
                job.bytes_a = gbuf_next;
                job.len_a = ghave_next;
                gbuf_next = '0;
                ghave_next = '0;
                gneed_next = '0;
            end
        end
        else if (mode_reg == MODE_ESC)
        begin
            if (text_byte == LBRK_CODE)
            begin
                mode_next = MODE_SGR;
                cnt_next = '0;
                acc_next = '0;
            end
            else
            begin
                job.cell_a = 1'b1;
                job.bytes_a = {24'd0, ESC_CODE};
                job.len_a = 3'd1;
                mode_next = MODE_TEXT;
                txt = 1'b1;
            end
        end
        else if (mode_reg == MODE_SGR)
        begin
            if (text_byte == SEMI_CODE)
                push = 1'b1;
            else if (text_byte >= ZERO_CODE && text_byte <= NINE_CODE)
                acc_next = (acc_x10 > {4'd0, NUM_MAX}) ? NUM_MAX : acc_x10[NUM_BITS-1:0];
            else if (text_byte == M_CODE)
            begin
                push = 1'b1;
                job.is_run = 1'b1;
                mode_next = MODE_TEXT;
            end
        end
        else
            txt = 1'b1;

        // Push the finished number
        pw_en   = accept && push && (cnt_reg < CW'(MAX_PARAMS));
        pw_addr = cnt_reg;
        pw_data = acc_reg;
        if (push)
        begin
            if (cnt_reg < CW'(MAX_PARAMS))
                cnt_next = cnt_reg + CW'(1);
            acc_next = '0;
        end

        // Ordinary text handling, possibly after an ESC cell
        if (txt)
        begin
            len = (tb == ESC_CODE) ? 3'd1 : lead_length(tb);
            if (tb == CR_CODE)
                ;
            else if (tb == LF_CODE)
            begin
                if (!job.cell_a && rows_reg != 8'hFF)
                    rows_next = rows_reg + 8'd1;
                else if (job.cell_a)
                    rows_next = 8'd1;
            end
            else if (tb == ESC_CODE && !stream_end)
                mode_next = MODE_ESC;
            else if (len == 3'd1 || stream_end)
            begin
                if (job.cell_a)
                begin
                    job.cell_b = 1'b1;
                    job.byte_b = tb;
                end
                else
                begin
                    job.cell_a = 1'b1;
                    job.bytes_a = {24'd0, tb};
                    job.len_a = 3'd1;
                end
            end
            else
            begin
                gbuf_next = {24'd0, tb};
                ghave_next = 3'd1;
                gneed_next = len;
            end
        end
        if (job.cell_a && !(txt && tb == LF_CODE))
            rows_next = '0;
        if (job.cell_a && txt && tb == LF_CODE)
            rows_next = 8'd1;
        if (job.cell_b)
            rows_next = '0;

        job_valid = accept && (job.cell_a || job.is_run || stream_end);

        if (stream_end)
        begin
            mode_next = MODE_TEXT;
            gbuf_next = '0;
            gneed_next = '0;
            ghave_next = '0;
            cnt_next = '0;
            acc_next = '0;
            rows_next = '0;
            job.is_run = 1'b0;
        end
    end
endmodule

// ===== hw/rtl/atcp_queue.sv =====
// ----------------------------------------------------------------------------
// atcp_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module atcp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  atcp_pkg::job_t  wr_job,
    output logic            rd_valid,
    input  logic            rd_ready,
    output atcp_pkg::job_t  rd_job
);
    import atcp_pkg::*;

    job_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    // Store payload
    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_job;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ===== hw/rtl/atcp_back.sv =====
// ----------------------------------------------------------------------------
// atcp_back
// Holds the colours, scans a stored SGR run one number a cycle (re-reading a number
// after 38 or 48 that is not 2) and sends cells out through an output register.
// ----------------------------------------------------------------------------
module atcp_back #(
    parameter int MAX_PARAMS = 16,
    parameter int NUM_BITS   = 16,
    parameter int CW         = $clog2(MAX_PARAMS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  atcp_pkg::job_t      job,
    input  logic [CW-1:0]       run_count,
    output logic                scanning,
    input  logic                pw_en,
    input  logic [CW-1:0]       pw_addr,
    input  logic [NUM_BITS-1:0] pw_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [103:0]        out_data
);
    import atcp_pkg::*;

    localparam int AW = $clog2(MAX_PARAMS);

    logic [NUM_BITS-1:0] pstore [MAX_PARAMS];
    bk_state_t           st_reg, st_next;
    colour_t             fg_reg, fg_next, bg_reg, bg_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [2:0]          sub_reg, sub_next;   // 0 code, 1 mode, 2..4 rgb
    logic                which_reg, which_next;
    logic [7:0]          r_reg, r_next, g_reg, g_next;
    logic                ob_reg, ob_next;     // never set: a second cell is tracked by BK_EMIT
    logic                ov_reg, ov_next;
    logic [103:0]        od_reg, od_next;
    job_t                jb_reg, jb_next;
    logic [NUM_BITS-1:0] pv;
    logic                out_free;

    // Parameter store: written by the front end, read by the scan
    always_ff @(posedge clk)
    begin
        if (pw_en)
            pstore[pw_addr[AW-1:0]] <= pw_data;
    end
    assign pv = pstore[n_reg[AW-1:0]];

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign scanning  = (st_reg == BK_SCAN);
    assign job_ready = (st_reg == BK_IDLE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            fg_reg <= '0;
            bg_reg <= '0;
            n_reg  <= '0;
            sub_reg <= '0;
            which_reg <= 1'b0;
            ob_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            fg_reg <= fg_next;
            bg_reg <= bg_next;
            n_reg  <= n_next;
            sub_reg <= sub_next;
            which_reg <= which_next;
            ob_reg <= ob_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        g_reg  <= g_next;
        od_reg <= od_next;
        jb_reg <= jb_next;
    end

    // Cell fields from bit 0 up, run_last kept apart in the top bit
    function automatic logic [103:0] pack_cell(input logic [31:0] b, input logic [2:0] l,
                                               input logic [7:0] rw, input colour_t f,
                                               input colour_t k, input logic last);
        return {last, 10'd0, k.blue, k.green, k.red, k.on, f.blue, f.green, f.red, f.on,
                rw, l, b};
    endfunction

    // Sequence cells and the run scan
    always_comb
    begin
        st_next = st_reg;
        fg_next = fg_reg;
        bg_next = bg_reg;
        n_next = n_reg;
        sub_next = sub_reg;
        which_next = which_reg;
        r_next = r_reg;
        g_next = g_reg;
        ob_next = ob_reg;
        ov_next = ov_reg && !out_ready;
        od_next = od_reg;
        jb_next = jb_reg;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (job_valid && out_free)
                begin
                    jb_next = job;
                    if (job.is_run)
                    begin
                        st_next = BK_SCAN;
                        n_next = '0;
                        sub_next = '0;
                    end
                    else
                    begin
                        if (job.cell_a)
                        begin
                            ov_next = 1'b1;
                            od_next = pack_cell(job.bytes_a, job.len_a, job.rows_a,
                                                fg_reg, bg_reg, !job.cell_b);
                        end
                        if (job.cell_b)
                        begin
                            st_next = BK_EMIT;
                        end
                        else if (job.flush)
                        begin
                            fg_next = '0;
                            bg_next = '0;
                        end
                    end
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next = pack_cell({24'd0, jb_reg.byte_b}, 3'd1, 8'd0,
                                        fg_reg, bg_reg, 1'b1);
                    if (jb_reg.flush)
                    begin
                        fg_next = '0;
                        bg_next = '0;
                    end
                    st_next = BK_IDLE;
                end
            end
            BK_SCAN:
            begin
                if (n_reg >= run_count)
                    st_next = BK_IDLE;
                else
                begin
                    n_next = n_reg + CW'(1);
                    unique case (sub_reg)
                        3'd0:
                        begin
                            if (pv == '0)
                            begin
                                fg_next = '0;
                                bg_next = '0;
                            end
                            else if ((pv == NUM_BITS'(FG_CODE) || pv == NUM_BITS'(BG_CODE))
                                     && ({1'b0, n_reg} + (CW+1)'(4) < {1'b0, run_count}))
                            begin
                                which_next = (pv == NUM_BITS'(BG_CODE));
                                sub_next = 3'd1;
                            end
                        end
                        3'd1:
                        begin
                            if (pv == NUM_BITS'(TC_CODE))
                                sub_next = 3'd2;
                            else
                            begin
                                // not a colour: re-read this number singly
                                sub_next = 3'd0;
                                n_next = n_reg;
                            end
                        end
                        3'd2:
                        begin
                            r_next = pv[7:0];
                            sub_next = 3'd3;
                        end
                        3'd3:
                        begin
                            g_next = pv[7:0];
                            sub_next = 3'd4;
                        end
                        3'd4:
                        begin
                            sub_next = 3'd0;
                            if (which_reg)
                                bg_next = '{1'b1, r_reg, g_reg, pv[7:0]};
                            else
                                fg_next = '{1'b1, r_reg, g_reg, pv[7:0]};
                        end
                        default:
                            sub_next = 3'd0;
                    endcase
                end
            end
            default:
                st_next = BK_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/ansi_truecolor_cell_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_truecolor_cell_parser
// Byte stream in, coloured character cells out.
// ----------------------------------------------------------------------------
// Ordinary bytes are taken one per cycle while the queue has room and no
// colour run is pending. The closing 'm' of a colour run holds the input
// while the back end walks the stored parameters one per cycle, reading a
// number again after each 38 or 48 not followed by a 2, and longer while
// earlier cells still wait for the output; a byte that yields two cells
// sends them out one after the other. A two-entry queue separates the
// byte classifier from the colour and output stage.
// ----------------------------------------------------------------------------
`include "ansi_truecolor_cell_parser_macros.svh"

module ansi_truecolor_cell_parser #(
    parameter int MAX_PARAMS = 16,
    parameter int NUM_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // text_byte
    input  logic         s_tlast,   // stream_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // glyph_bytes, glyph_length, rows_before, fore_on, fore_red, fore_green,
    // fore_blue, back_on, back_red, back_green, back_blue
    output logic [95:0]  m_tdata,
    output logic         m_tlast    // run_last
);
    import atcp_pkg::*;

    localparam int CW = $clog2(MAX_PARAMS + 1);

    logic                fj_valid, fj_ready, bj_valid, bj_ready;
    job_t                fj, bj;
    logic [CW-1:0]       run_count;
    logic                pw_en, scanning, hold;
    logic                hold_q;
    logic [CW-1:0]       pw_addr;
    logic [NUM_BITS-1:0] pw_data;
    logic [103:0]        od;

    // Stall input while a run job is queued or being scanned
    assign hold = scanning || (bj_valid && bj.is_run) || (fj_valid && fj.is_run);

    atcp_front #(.MAX_PARAMS(MAX_PARAMS), .NUM_BITS(NUM_BITS), .CW(CW)) u_front (
        .clk, .rst_n,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .text_byte(s_tdata), .stream_end(s_tlast),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj),
        .run_busy(hold_q), .run_count(run_count),
        .pw_en, .pw_addr, .pw_data
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) hold_q <= 1'b0;
        else        hold_q <= hold || (fj_valid && fj.is_run);
    end

    atcp_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
    );

    atcp_back #(.MAX_PARAMS(MAX_PARAMS), .NUM_BITS(NUM_BITS), .CW(CW)) u_back (
        .clk, .rst_n,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .run_count, .scanning,
        .pw_en, .pw_addr, .pw_data,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(od)
    );

    assign m_tdata = od[95:0];
    assign m_tlast = od[103];

    // Checks
    `ATC_ASSERT_IMP(a_len_range, m_tvalid, (od[34:32] != 3'd0 && od[34:32] <= 3'd4),
                    "cell length out of range")
    `ATC_ASSERT_IMP(a_no_accept_scan, scanning, !(s_tvalid && s_tready),
                    "input accepted during run scan")
    `ATC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(od),
                    "output word changed while stalled")
endmodule
